// File: rtl/rdmg_pkg.sv
// Package for the random DFS maze generator: sizes, cell codes, frame type, LFSR step.
// No dependencies.
package rdmg_pkg;
    localparam int MAZE_WIDTH  = 41;
    localparam int MAZE_HEIGHT = 31;
    localparam int STACK_DEPTH = 512;
    localparam int GRID_DEPTH  = MAZE_WIDTH * MAZE_HEIGHT;
    localparam int GRID_AW     = $clog2(GRID_DEPTH);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);

    localparam logic [1:0] CELL_FLOOR = 2'd0;
    localparam logic [1:0] CELL_WALL  = 2'd1;
    localparam logic [1:0] CELL_START = 2'd2;
    localparam logic [1:0] CELL_GOAL  = 2'd3;

    localparam logic KIND_GEN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // One stack frame: position, direction order, next index (0..4).
    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] order;
        logic [2:0] next;
    } frame_t;
    localparam int FRAME_W = $bits(frame_t);

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic b;
        b = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {b, v[15:1]};
    endfunction

    // Row-major address, y*W + x.
    function automatic logic [GRID_AW-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y);
        logic [12:0] a;
        a = 13'(y) * 13'(MAZE_WIDTH) + 13'(x);
        return a[GRID_AW-1:0];
    endfunction
endpackage

// File: rtl/rdmg_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rdmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/rdmg_shuffle.sv
// Fisher-Yates shuffle of four directions with three LFSR draws, combinational.
// Depends on rdmg_pkg.
module rdmg_shuffle (
    input  logic [15:0] lfsr_in,
    output logic [15:0] lfsr_out,
    output logic [7:0]  order
);
    import rdmg_pkg::*;
    logic [15:0] r1, r2, r3;
    logic [1:0]  o [4];
    logic [1:0]  j3, j2, t;
    logic [16:0] m3;

    always_comb
    begin
        r1 = lfsr_step(lfsr_in);
        r2 = lfsr_step(r1);
        r3 = lfsr_step(r2);
        for (int i = 0; i < 4; i++)
        begin
            o[i] = 2'(i);
        end
        j3 = r1[1:0];
        t = o[3]; o[3] = o[j3]; o[j3] = t;
        // mod 3 via reciprocal: q = (r*0xAAAB)>>17
        m3 = 17'(r2) - 17'(((33'(r2) * 33'h0AAAB) >> 17) * 3);
        j2 = m3[1:0];
        t = o[2]; o[2] = o[j2]; o[j2] = t;
        // j = r3 mod 2; j == 0 swaps positions 1 and 0
        if (!r3[0])
        begin
            t = o[1]; o[1] = o[0]; o[0] = t;
        end
        order = {o[3], o[2], o[1], o[0]};
        lfsr_out = r3;
    end
endmodule

// File: rtl/random_dfs_maze_generator.sv
// Random DFS maze generator, top level: handshake, APB seed register, walk sequencer.
// Depends on rdmg_pkg, rdmg_ram, rdmg_shuffle.
// Read request: one grid RAM read, through S_RD0 and S_RD1, then out_valid rises.
// Generate request: wall fill of all GRID_DEPTH cells, then the walk, which tries each
// direction of the top frame in its shuffled order and pops the frame once all are tried.
// One request at a time; in_ready returns once the result is taken. Reset (rst_n low,
// async) clears control, seed=1; grid reads as all wall until the first generate.
module random_dfs_maze_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        done_kind,
    output logic [1:0]  cell_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rdmg_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD0    = 4'd1;  // grid data back
    localparam logic [3:0] S_RD1    = 4'd2;  // raise result
    localparam logic [3:0] S_FILL   = 4'd3;
    localparam logic [3:0] S_TOP    = 4'd4;  // read top frame
    localparam logic [3:0] S_FRAME  = 4'd5;  // frame data back
    localparam logic [3:0] S_NBR    = 4'd6;  // neighbour cell data back
    localparam logic [3:0] S_START  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_PUSH0  = 4'd9;  // enter (1,1)
    localparam logic [3:0] S_ENTER  = 4'd10; // enter carved neighbour

    logic [3:0]          state_reg, state_next;
    logic [15:0]         seed_reg;
    logic [15:0]         lfsr_reg, lfsr_next;
    logic [STACK_AW:0]   sp_reg, sp_next;
    logic [GRID_AW-1:0]  fill_reg, fill_next;
    logic                built_reg, built_next;
    logic                kind_reg, kind_next;
    logic [1:0]          code_reg, code_next;
    logic                rd_oob_reg, rd_oob_next;
    frame_t              frm_reg, frm_next;
    logic [5:0]          nx_reg, nx_next, ny_reg, ny_next;
    logic [5:0]          wx_reg, wx_next, wy_reg, wy_next;
    logic                nok_reg, nok_next;
    logic                ovalid_reg, ovalid_next;

    // grid RAM
    logic               g_we;
    logic [GRID_AW-1:0] g_waddr, g_raddr;
    logic [1:0]         g_wdata, g_rdata;
    // stack RAM
    logic                s_we;
    logic [STACK_AW-1:0] s_waddr, s_raddr;
    frame_t              s_wdata, s_rdata;
    logic [FRAME_W-1:0]  s_rbits;

    logic [15:0] sh_lfsr;
    logic [7:0]  sh_order;

    rdmg_ram #(.WIDTH(2), .DEPTH(GRID_DEPTH)) u_grid (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata));

    rdmg_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rbits));
    assign s_rdata = frame_t'(s_rbits);

    rdmg_shuffle u_shuf (.lfsr_in(lfsr_reg), .lfsr_out(sh_lfsr), .order(sh_order));

    // APB seed register; a zero seed is stored as written and replaced by 1 when loaded into the LFSR
    assign pready = 1'b1;
    assign prdata = {16'd0, seed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 16'd1;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            seed_reg <= pwdata[15:0];
        end
    end

    // new request only once the previous result has left
    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign done_kind = kind_reg;
    assign cell_code = code_reg;

    // Current frame direction and its neighbour
    logic [1:0] dir;
    logic [6:0] cx7, cy7;
    always_comb
    begin
        dir = 2'(frm_reg.order >> {frm_reg.next[1:0], 1'b0});
        cx7 = {1'b0, frm_reg.x};
        cy7 = {1'b0, frm_reg.y};
        unique case (dir)
            2'd0: cy7 = cy7 + 7'd2;
            2'd1: cx7 = cx7 + 7'd2;
            2'd2: cy7 = cy7 - 7'd2;
            default: cx7 = cx7 - 7'd2;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        lfsr_next   = lfsr_reg;
        sp_next     = sp_reg;
        fill_next   = fill_reg;
        built_next  = built_reg;
        kind_next   = kind_reg;
        code_next   = code_reg;
        rd_oob_next = rd_oob_reg;
        frm_next    = frm_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        wx_next     = wx_reg;
        wy_next     = wy_reg;
        nok_next    = nok_reg;
        ovalid_next = ovalid_reg && !out_ready;
        g_we = 1'b0; g_waddr = '0; g_wdata = CELL_WALL; g_raddr = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = frm_reg; s_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    kind_next = kind;
                    if (kind == KIND_READ)
                    begin
                        rd_oob_next = (cell_x >= 6'(MAZE_WIDTH)) ||
                                      (cell_y >= 6'(MAZE_HEIGHT));
                        g_raddr = cell_addr(cell_x, cell_y);
                        state_next = S_RD0;
                    end
                    else
                    begin
                        lfsr_next = (seed_reg == 16'd0) ? 16'd1 : seed_reg;
                        fill_next = '0;
                        state_next = S_FILL;
                    end
                end
            end
            S_RD0:
            begin
                // registered read issued at accept is valid here
                code_next = (rd_oob_reg || !built_reg) ? CELL_WALL : g_rdata;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                g_we = 1'b1; g_waddr = fill_reg; g_wdata = CELL_WALL;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == GRID_AW'(GRID_DEPTH - 1))
                begin
                    built_next = 1'b1;
                    state_next = S_PUSH0;
                end
            end
            S_PUSH0:
            begin
                // enter (1,1): floor and push
                g_we = 1'b1; g_waddr = cell_addr(6'd1, 6'd1); g_wdata = CELL_FLOOR;
                s_we = 1'b1; s_waddr = '0;
                s_wdata = '{x: 6'd1, y: 6'd1, order: sh_order, next: 3'd0};
                lfsr_next = sh_lfsr;
                sp_next = (STACK_AW+1)'(1);
                state_next = S_TOP;
            end
            S_TOP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_START;
                end
                else
                begin
                    s_raddr = STACK_AW'(sp_reg - 1'b1);
                    state_next = S_FRAME;
                end
            end
            S_FRAME:
            begin
                frm_next = s_rdata;
                if (s_rdata.next[2])
                begin
                    sp_next = sp_reg - 1'b1;
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_NBR;
                end
            end
            S_NBR:
            begin
                // phase A (nok=0): bump next, write back, issue neighbour read
                // phase B (nok=1): check wall and carve
                if (!nok_reg)
                begin
                    s_we = 1'b1; s_waddr = STACK_AW'(sp_reg - 1'b1);
                    s_wdata = frm_reg;
                    s_wdata.next = frm_reg.next + 3'd1;
                    nx_next = cx7[5:0];
                    ny_next = cy7[5:0];
                    wx_next = 6'((cx7 + {1'b0, frm_reg.x}) >> 1);
                    wy_next = 6'((cy7 + {1'b0, frm_reg.y}) >> 1);
                    g_raddr = cell_addr(cx7[5:0], cy7[5:0]);
                    if (!cx7[6] && !cy7[6] && cx7 < 7'(MAZE_WIDTH) &&
                        cy7 < 7'(MAZE_HEIGHT))
                    begin
                        nok_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_TOP;
                    end
                end
                else
                begin
                    // the registered read issued in phase A is valid now
                    nok_next = 1'b0;
                    state_next = S_TOP;
                    if (g_rdata == CELL_WALL)
                    begin
                        // carve wall between, then enter neighbour
                        g_we = 1'b1; g_waddr = cell_addr(wx_reg, wy_reg);
                        g_wdata = CELL_FLOOR;
                        state_next = S_ENTER;
                    end
                end
            end
            S_ENTER:
            begin
                // enter neighbour: floor, push if room
                g_we = 1'b1; g_waddr = cell_addr(nx_reg, ny_reg); g_wdata = CELL_FLOOR;
                if (sp_reg < (STACK_AW+1)'(STACK_DEPTH))
                begin
                    s_we = 1'b1; s_waddr = STACK_AW'(sp_reg);
                    s_wdata = '{x: nx_reg, y: ny_reg, order: sh_order, next: 3'd0};
                    lfsr_next = sh_lfsr;
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_TOP;
            end
            S_START:
            begin
                g_we = 1'b1; g_waddr = cell_addr(6'd1, 6'd1); g_wdata = CELL_START;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                g_we = 1'b1;
                g_waddr = cell_addr(6'(MAZE_WIDTH - 2), 6'(MAZE_HEIGHT - 2));
                g_wdata = CELL_GOAL;
                code_next = CELL_FLOOR;
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lfsr_reg   <= 16'd1;
            sp_reg     <= '0;
            fill_reg   <= '0;
            built_reg  <= 1'b0;
            nok_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            kind_reg   <= 1'b0;
            code_reg   <= CELL_WALL;
        end
        else
        begin
            state_reg  <= state_next;
            lfsr_reg   <= lfsr_next;
            sp_reg     <= sp_next;
            fill_reg   <= fill_next;
            built_reg  <= built_next;
            nok_reg    <= nok_next;
            ovalid_reg <= ovalid_next;
            kind_reg   <= kind_next;
            code_reg   <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_oob_reg <= rd_oob_next;
        frm_reg    <= frm_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        wx_reg     <= wx_next;
        wy_reg     <= wy_next;
    end
endmodule

// File: rtl/rdmg_checker.sv
// Port-level checker for the maze generator, bound to the top level.
// Depends on random_dfs_maze_generator ports only.
module rdmg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       done_kind,
    input logic [1:0] cell_code,
    input logic       pready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_code) && $stable(done_kind))
        else $error("result dropped while stalled");
    a_gen_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_kind |-> cell_code == 2'd0)
        else $error("generate result not zero");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind random_dfs_maze_generator rdmg_checker u_rdmg_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .done_kind(done_kind),
    .cell_code(cell_code), .pready(pready));

// File: dv/tb_random_dfs_maze_generator.sv
// Testbench for random_dfs_maze_generator: drives generate and cell-read requests,
// checks each result against an in-bench maze predictor. Depends on rdmg_pkg and the RTL.
module tb_random_dfs_maze_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import rdmg_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = KIND_READ;
    logic [5:0]  cell_x = '0;
    logic [5:0]  cell_y = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        done_kind;
    logic [1:0]  cell_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [1:0] ADDR_SEED = 2'd0;

    random_dfs_maze_generator u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        logic       kind;
        logic [1:0] code;
    } answer_t;

    // Predictor state: grid, walk stack, LFSR and seed register.
    logic [1:0]  maze_grid [MAZE_HEIGHT][MAZE_WIDTH];
    logic [5:0]  walk_x [STACK_DEPTH];
    logic [5:0]  walk_y [STACK_DEPTH];
    logic [1:0]  walk_dir [STACK_DEPTH][4];
    logic [2:0]  walk_next [STACK_DEPTH];
    int          walk_depth;
    logic [15:0] maze_lfsr;
    logic [15:0] seed_reg = 16'd1;
    answer_t     pending_answers[$];

    int  fail_count = 0;
    int  gen_count = 0;
    int  read_count = 0;
    int  answer_count = 0;
    bit  quiet_mode = 1'b0;
    bit  hold_off = 1'b0;

    function automatic logic [15:0] next_lfsr(input logic [15:0] v);
        return {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
    endfunction

    // Mark a cell floor and push a shuffled frame if the stack has room.
    function automatic void visit_cell(input int x, input int y);
        int j;
        logic [1:0] t;
        maze_grid[y][x] = CELL_FLOOR;
        if (walk_depth >= STACK_DEPTH)
            return;
        walk_x[walk_depth] = 6'(x);
        walk_y[walk_depth] = 6'(y);
        for (int i = 0; i < 4; i++)
            walk_dir[walk_depth][i] = 2'(i);
        for (int i = 3; i > 0; i--)
        begin
            maze_lfsr = next_lfsr(maze_lfsr);
            j = int'(maze_lfsr) % (i + 1);
            t = walk_dir[walk_depth][i];
            walk_dir[walk_depth][i] = walk_dir[walk_depth][j];
            walk_dir[walk_depth][j] = t;
        end
        walk_next[walk_depth] = 3'd0;
        walk_depth++;
    endfunction

    function automatic void carve_maze();
        int d, nx, ny, top, dx, dy;
        maze_lfsr = (seed_reg != 0) ? seed_reg : 16'd1;
        foreach (maze_grid[y, x])
            maze_grid[y][x] = CELL_WALL;
        walk_depth = 0;
        visit_cell(1, 1);
        while (walk_depth > 0)
        begin
            top = walk_depth - 1;
            if (walk_next[top] >= 4)
            begin
                walk_depth--;
                continue;
            end
            d = walk_dir[top][walk_next[top][1:0]];
            walk_next[top]++;
            dx = (d == 1) ? 2 : (d == 3) ? -2 : 0;
            dy = (d == 0) ? 2 : (d == 2) ? -2 : 0;
            nx = int'(walk_x[top]) + dx;
            ny = int'(walk_y[top]) + dy;
            if (nx >= 0 && nx < MAZE_WIDTH && ny >= 0 && ny < MAZE_HEIGHT &&
                maze_grid[ny][nx] == CELL_WALL)
            begin
                maze_grid[ny - dy / 2][nx - dx / 2] = CELL_FLOOR;
                visit_cell(nx, ny);
            end
        end
        maze_grid[1][1] = CELL_START;
        maze_grid[MAZE_HEIGHT - 2][MAZE_WIDTH - 2] = CELL_GOAL;
    endfunction

    function automatic answer_t predict_answer(input logic k, input logic [5:0] x,
                                               input logic [5:0] y);
        answer_t a;
        a.kind = k;
        a.code = CELL_FLOOR;
        if (k == KIND_GEN)
            carve_maze();
        else if (x < MAZE_WIDTH && y < MAZE_HEIGHT)
            a.code = maze_grid[y][x];
        else
            a.code = CELL_WALL;
        return a;
    endfunction

    initial
    begin
        foreach (maze_grid[y, x])
            maze_grid[y][x] = CELL_WALL;
        maze_lfsr = 16'd1;
        walk_depth = 0;
    end

    // Send one request; a typed expected code (when has_code) is checked against
    // the predictor too, so table errors show up as failures. Valid is dropped
    // only before an idle gap or by drain_answers, so back-to-back requests
    // keep it high.
    task automatic send_request(input logic k, input logic [5:0] x, input logic [5:0] y,
                                input bit has_code, input logic [1:0] code);
        answer_t a;
        if (!quiet_mode && ($urandom_range(0, 3) == 0))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        cell_x <= x;
        cell_y <= y;
        do @(posedge clk); while (!in_ready);
        a = predict_answer(k, x, y);
        if (has_code && a.code !== code)
        begin
            $error("table row code: expected %0d, predictor %0d", code, a.code);
            fail_count++;
        end
        pending_answers.push_back(a);
        if (k == KIND_GEN)
            gen_count++;
        else
            read_count++;
    endtask

    task automatic write_seed(input logic [15:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_SEED;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        seed_reg = value;
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off, checks each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                answer_count++;
                if (pending_answers.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d code %0d",
                           done_kind, cell_code);
                    fail_count++;
                end
                else
                begin
                    answer_t a;
                    a = pending_answers.pop_front();
                    if (done_kind !== a.kind)
                    begin
                        $error("done_kind: expected %0d, actual %0d", a.kind, done_kind);
                        fail_count++;
                    end
                    if (cell_code !== a.code)
                    begin
                        $error("cell_code: expected %0d, actual %0d", a.code, cell_code);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 15);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    typedef struct {
        logic       kind;
        logic [5:0] x;
        logic [5:0] y;
        bit         has_code;
        logic [1:0] code;
    } table_row_t;

    // Directed rows: reads before any maze, a maze, then reads of start, goal, extremes and out-of-grid cells.
    table_row_t directed_rows[] = '{
        '{KIND_READ, 6'd0,  6'd0,  1, CELL_WALL},
        '{KIND_READ, 6'd1,  6'd1,  1, CELL_WALL},
        '{KIND_READ, 6'd63, 6'd63, 1, CELL_WALL},
        '{KIND_GEN,  6'd63, 6'd63, 1, CELL_FLOOR},
        '{KIND_READ, 6'd1,  6'd1,  1, CELL_START},
        '{KIND_READ, 6'd39, 6'd29, 1, CELL_GOAL},
        '{KIND_READ, 6'd0,  6'd0,  1, CELL_WALL},
        '{KIND_READ, 6'd40, 6'd30, 1, CELL_WALL},
        '{KIND_READ, 6'd41, 6'd0,  1, CELL_WALL},
        '{KIND_READ, 6'd0,  6'd31, 1, CELL_WALL},
        '{KIND_READ, 6'd63, 6'd0,  1, CELL_WALL},
        '{KIND_READ, 6'd0,  6'd63, 1, CELL_WALL},
        '{KIND_READ, 6'd2,  6'd1,  0, CELL_FLOOR},
        '{KIND_READ, 6'd1,  6'd2,  0, CELL_FLOOR},
        '{KIND_READ, 6'd21, 6'd15, 0, CELL_FLOOR},
        '{KIND_READ, 6'd42, 6'd21, 0, CELL_FLOOR}
    };

    localparam logic [15:0] SEED_LIST [5] = '{16'hFFFF, 16'h0000, 16'hACE1, 16'h8000, 16'h0001};

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
                         directed_rows[i].has_code, directed_rows[i].code);
        drain_answers();

        // Long receiver hold-off while reads keep coming, so the input stalls.
        hold_off = 1'b1;
        fork
            repeat (8) send_request(KIND_READ, 6'($urandom), 6'($urandom), 0, CELL_FLOOR);
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain_answers();

        // Each phase: a new seed, a maze, then mostly in-grid reads and sometimes a second maze.
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 5)
                write_seed(SEED_LIST[phase]);
            else
                write_seed(16'($urandom));
            if (phase == 7)
                quiet_mode = 1'b1;
            send_request(KIND_GEN, 6'($urandom), 6'($urandom), 0, CELL_FLOOR);
            for (int n = 0; n < 34; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(KIND_READ, 6'($urandom), 6'($urandom), 0, CELL_FLOOR);
                else
                    send_request(KIND_READ, 6'($urandom_range(0, MAZE_WIDTH - 1)),
                                 6'($urandom_range(0, MAZE_HEIGHT - 1)), 0, CELL_FLOOR);
            end
            if ($urandom_range(0, 1) == 1)
                send_request(KIND_GEN, 6'($urandom), 6'($urandom), 0, CELL_FLOOR);
            drain_answers();
        end

        drain_answers();
        $display("Covered %0d generate and %0d read requests, %0d results checked,",
                 gen_count, read_count, answer_count);
        $display("with seed extremes, zero seed and out-of-grid reads.");
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
